FILE: hdl/rrct_pkg.sv
// shared types and constants for the radio range crossing time block
package rrct_pkg;

  localparam int TIME_FRAC_BITS = 16;
  localparam logic [30:0] RANGE_RESET = 31'd6553600;
  localparam logic [23:0] STEP_MAX = 24'hFFFFFF;
  localparam logic [23:0] STEP_ONE = 24'd1 << TIME_FRAC_BITS;

  typedef struct packed {
    logic [22:0]        hor;
    logic signed [32:0] px;
    logic signed [32:0] py;
    logic signed [32:0] vx;
    logic signed [32:0] vy;
    logic [63:0]        pxx;
    logic [63:0]        pyy;
    logic [63:0]        vxx;
    logic [63:0]        vyy;
    logic signed [65:0] dx;
    logic signed [65:0] dy;
    logic [64:0]        pp;
    logic [64:0]        vv;
    logic signed [66:0] dot;
    logic               inr;
    logic               dneg;
    logic [65:0]        dmag;
    logic [32:0]        sv;
    logic [32:0]        sp;
    logic [34:0]        tm;
    logic [69:0]        t2;
    logic [64:0]        cd2;
    logic               miss;
    logic [61:0]        rad;
    logic [30:0]        back;
    logic               eok;
    logic [34:0]        num;
    logic               ovf;
    logic [23:0]        q;
  } item_t;

endpackage

FILE: hdl/radio_range_crossing_time.sv
// top level: link state and time to next link change for a pair of moving nodes
//
// s_* carries one node pair per transaction, m_* one result per pair, in order.
// cfg_* writes the radio range (unsigned Q15.16); it is always ready and
// should only be written while no pair is in flight.
// The datapath is a single pipeline of 134 register stages: four input
// stages, a 33-stage root of the squared speed, one stage to register the
// roots, a 35-stage divider for the closest approach, three stages of squares
// and compares, a 31-stage root for the entry distance, two stages to form the
// final numerator, a 24-stage divider and one result stage. One pair is
// accepted every cycle while the output is not stalled.
// The result stage doubles as the output register. When m_tready is low with
// a result waiting, the whole pipeline holds and s_tready drops in the same
// cycle; nothing is lost or repeated.
// Reset clears all valid bits and sets the range to 100.0; no clearing
// sweep is needed.
module radio_range_crossing_time (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_pos_x, a_pos_y, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_vel_x, b_vel_y, horizon
  input  logic [279:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // in_range, step_time, step_saturated
  output logic [31:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [30:0]  cfg_data
);

  logic        en;
  logic [30:0] radio_range;
  logic [61:0] r2;

  logic            front_vld, v_vld, g1_vld, dt_vld, h1_vld, h2_vld, h3_vld;
  logic            b_vld, j_vld, k_vld, ds_vld, l_vld;
  rrct_pkg::item_t front_it, v_it, g1, dt_it, h1, h2, h3, b_it, j, k, ds_it;
  rrct_pkg::item_t g1_next, h1_next, h2_next, h3_next, j_next, k_next;
  logic [32:0]     root_v, root_p;
  logic [34:0]     q_t;
  logic [30:0]     root_b;
  logic [23:0]     q_s;
  logic            out_inr, out_sat;
  logic [23:0]     out_step;

  assign en        = !l_vld || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radio_range <= rrct_pkg::RANGE_RESET;
    end else if (cfg_valid) begin
      radio_range <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    r2 <= radio_range * radio_range;
  end

  rrct_front u_front (
    .clk(clk), .rst(rst), .en(en), .vld_i(s_tvalid && en), .data_i(s_tdata),
    .r2(r2), .vld_o(front_vld), .item_o(front_it)
  );

  rrct_isqrt #(.OUT_W(33), .side_t(rrct_pkg::item_t)) u_sqrt_v (
    .clk(clk), .rst(rst), .en(en), .vld_i(front_vld), .rad_i({1'b0, front_it.vv}),
    .side_i(front_it), .vld_o(v_vld), .root_o(root_v), .side_o(v_it)
  );

  rrct_isqrt #(.OUT_W(33)) u_sqrt_p (
    .clk(clk), .rst(rst), .en(en), .vld_i(front_vld), .rad_i({1'b0, front_it.pp}),
    .side_i(1'b0), .vld_o(), .root_o(root_p), .side_o()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      g1_vld <= 1'b0;
      h1_vld <= 1'b0;
      h2_vld <= 1'b0;
      h3_vld <= 1'b0;
      j_vld  <= 1'b0;
      k_vld  <= 1'b0;
      l_vld  <= 1'b0;
    end else if (en) begin
      g1_vld <= v_vld;
      h1_vld <= dt_vld;
      h2_vld <= h1_vld;
      h3_vld <= h2_vld;
      j_vld  <= b_vld;
      k_vld  <= j_vld;
      l_vld  <= ds_vld;
    end
  end

  rrct_div #(.Q_W(35), .D_W(33), .side_t(rrct_pkg::item_t)) u_div_t (
    .clk(clk), .rst(rst), .en(en), .vld_i(g1_vld), .rem_i({2'b0, g1.dmag[65:35]}),
    .lo_i(g1.dmag[34:0]), .den_i(g1.sv), .side_i(g1),
    .vld_o(dt_vld), .q_o(q_t), .side_o(dt_it)
  );

  rrct_isqrt #(.OUT_W(31), .side_t(rrct_pkg::item_t)) u_sqrt_b (
    .clk(clk), .rst(rst), .en(en), .vld_i(h3_vld), .rad_i(h3.rad),
    .side_i(h3), .vld_o(b_vld), .root_o(root_b), .side_o(b_it)
  );

  rrct_div #(.Q_W(24), .D_W(33), .side_t(rrct_pkg::item_t)) u_div_s (
    .clk(clk), .rst(rst), .en(en), .vld_i(k_vld), .rem_i({6'b0, k.num[34:8]}),
    .lo_i({k.num[7:0], {rrct_pkg::TIME_FRAC_BITS{1'b0}}}), .den_i(k.sv), .side_i(k),
    .vld_o(ds_vld), .q_o(q_s), .side_o(ds_it)
  );

  always_comb begin
    g1_next    = v_it;
    g1_next.sv = root_v;
    g1_next.sp = root_p;

    h1_next    = dt_it;
    h1_next.tm = q_t;
    h1_next.t2 = q_t * q_t;

    h2_next     = h1;
    h2_next.cd2 = (h1.t2 < {5'b0, h1.pp}) ? 65'({5'b0, h1.pp} - h1.t2) : '0;

    h3_next      = h2;
    h3_next.miss = h2.cd2 > {3'b0, r2};
    h3_next.rad  = 62'({3'b0, r2} - h2.cd2);

    j_next      = b_it;
    j_next.back = root_b;
    j_next.eok  = (b_it.dneg || b_it.tm == '0) && b_it.tm >= {4'b0, root_b};
    j_next.num  = b_it.inr ? 35'({4'b0, radio_range} - {2'b0, b_it.sp})
                           : 35'(b_it.tm - {4'b0, root_b});

    k_next     = j;
    k_next.ovf = {6'b0, j.num[34:8]} >= j.sv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1 <= g1_next;
      h1 <= h1_next;
      h2 <= h2_next;
      h3 <= h3_next;
      j  <= j_next;
      k  <= k_next;

      out_inr <= ds_it.inr;
      if (ds_it.sv == '0) begin
        out_step <= rrct_pkg::STEP_MAX;
        out_sat  <= 1'b1;
      end else if (ds_it.inr) begin
        out_step <= ds_it.ovf ? rrct_pkg::STEP_MAX : q_s;
        out_sat  <= ds_it.ovf;
      end else begin
        out_sat <= 1'b0;
        if (ds_it.miss) begin
          out_step <= {1'b0, ds_it.hor};
        end else if (ds_it.eok && !ds_it.ovf && q_s <= {1'b0, ds_it.hor}) begin
          out_step <= q_s;
        end else begin
          out_step <= rrct_pkg::STEP_ONE;
        end
      end
    end
  end

  assign m_tvalid = l_vld;
  assign m_tdata  = {6'b0, out_sat, out_step, out_inr};

endmodule

FILE: hdl/rrct_front.sv
// input stages: relative motion, products and sums of squares
module rrct_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  vld_i,
  input  logic [279:0]          data_i,
  input  logic [61:0]           r2,
  output logic                  vld_o,
  output rrct_pkg::item_t       item_o
);

  rrct_pkg::item_t f1, f2, f3;
  rrct_pkg::item_t f1_next, f2_next, f3_next, item_next;
  logic [3:0] vld;
  logic [31:0] mpx, mpy, mvx, mvy;

  assign mpx = 32'(f1.px < 0 ? -f1.px : f1.px);
  assign mpy = 32'(f1.py < 0 ? -f1.py : f1.py);
  assign mvx = 32'(f1.vx < 0 ? -f1.vx : f1.vx);
  assign mvy = 32'(f1.vy < 0 ? -f1.vy : f1.vy);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], vld_i};
    end
  end

  always_comb begin
    f1_next     = '0;
    f1_next.px  = {data_i[31], data_i[31:0]} - {data_i[159], data_i[159:128]};
    f1_next.py  = {data_i[63], data_i[63:32]} - {data_i[191], data_i[191:160]};
    f1_next.vx  = {data_i[95], data_i[95:64]} - {data_i[223], data_i[223:192]};
    f1_next.vy  = {data_i[127], data_i[127:96]} - {data_i[255], data_i[255:224]};
    f1_next.hor = data_i[278:256];

    f2_next     = f1;
    f2_next.pxx = mpx * mpx;
    f2_next.pyy = mpy * mpy;
    f2_next.vxx = mvx * mvx;
    f2_next.vyy = mvy * mvy;
    f2_next.dx  = f1.px * f1.vx;
    f2_next.dy  = f1.py * f1.vy;

    f3_next     = f2;
    f3_next.pp  = 65'(f2.pxx) + 65'(f2.pyy);
    f3_next.vv  = 65'(f2.vxx) + 65'(f2.vyy);
    f3_next.dot = 67'(f2.dx) + 67'(f2.dy);

    item_next      = f3;
    item_next.inr  = f3.pp < {3'b0, r2};
    item_next.dneg = f3.dot[66];
    item_next.dmag = 66'(f3.dot[66] ? -f3.dot : f3.dot);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1     <= f1_next;
      f2     <= f2_next;
      f3     <= f3_next;
      item_o <= item_next;
    end
  end

  assign vld_o = vld[3];

endmodule

FILE: hdl/rrct_isqrt.sv
// pipelined integer square root, one root bit per stage
module rrct_isqrt #(
  parameter int OUT_W = 33,
  parameter type side_t = logic
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vld_i,
  input  logic [2*OUT_W-1:0] rad_i,
  input  side_t              side_i,
  output logic               vld_o,
  output logic [OUT_W-1:0]   root_o,
  output side_t              side_o
);

  localparam int IN_W = 2 * OUT_W;
  localparam int RW = OUT_W + 2;

  logic [RW-1:0]    rem_q  [OUT_W];
  logic [OUT_W-1:0] root_q [OUT_W];
  logic [IN_W-1:0]  x_q    [OUT_W];
  side_t            side_q [OUT_W];
  logic [OUT_W-1:0] vld_q;

  for (genvar k = 0; k < OUT_W; k++) begin : g_step
    logic [RW-1:0]    rem_in;
    logic [OUT_W-1:0] root_in;
    logic [IN_W-1:0]  x_in;
    side_t            side_in;
    logic             vld_in;
    logic [RW+1:0]    tv;
    logic [RW+1:0]    trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = rad_i;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign tv    = {rem_in, x_in[IN_W-1 -: 2]};
    assign trial = {2'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (tv >= trial) begin
          rem_q[k]  <= RW'(tv - trial);
          root_q[k] <= {root_in[OUT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= RW'(tv);
          root_q[k] <= {root_in[OUT_W-2:0], 1'b0};
        end
        x_q[k]    <= x_in << 2;
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[OUT_W-1];
  assign root_o = root_q[OUT_W-1];
  assign side_o = side_q[OUT_W-1];

endmodule

FILE: hdl/rrct_div.sv
// pipelined restoring divider, one quotient bit per stage
module rrct_div #(
  parameter int Q_W = 24,
  parameter int D_W = 33,
  parameter type side_t = logic
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vld_i,
  input  logic [D_W-1:0] rem_i,
  input  logic [Q_W-1:0] lo_i,
  input  logic [D_W-1:0] den_i,
  input  side_t          side_i,
  output logic           vld_o,
  output logic [Q_W-1:0] q_o,
  output side_t          side_o
);

  logic [D_W-1:0] rem_q  [Q_W];
  logic [Q_W-1:0] lo_q   [Q_W];
  logic [D_W-1:0] den_q  [Q_W];
  side_t          side_q [Q_W];
  logic [Q_W-1:0] vld_q;

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [D_W-1:0] rem_in;
    logic [Q_W-1:0] lo_in;
    logic [D_W-1:0] den_in;
    side_t          side_in;
    logic           vld_in;
    logic [D_W:0]   tv;

    if (k == 0) begin : g_first
      assign rem_in  = rem_i;
      assign lo_in   = lo_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign lo_in   = lo_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign tv = {rem_in, lo_in[Q_W-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (tv >= {1'b0, den_in}) begin
          rem_q[k] <= D_W'(tv - {1'b0, den_in});
          lo_q[k]  <= {lo_in[Q_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= D_W'(tv);
          lo_q[k]  <= {lo_in[Q_W-2:0], 1'b0};
        end
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[Q_W-1];
  assign q_o    = lo_q[Q_W-1];
  assign side_o = side_q[Q_W-1];

endmodule

FILE: hdl/rrct_checker.sv
// port-level checks for the radio range crossing time block
module rrct_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [31:0]  m_tdata
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // output stall reaches the input in the same cycle
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while output stalled");

  // a clipped step is always the maximum
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[25] |-> m_tdata[24:1] == 24'hFFFFFF)
    else $error("saturated step not at maximum");

endmodule

bind radio_range_crossing_time rrct_checker u_rrct_checker (.*);
